>>> rtl/eight_bit_cpu_execute_flags_defines.svh
// ----------------------------------------------------------------------------
// Execute unit assertion macros
// Shared concurrent assertion forms for the execute unit.
// ----------------------------------------------------------------------------
`ifndef EIGHT_BIT_CPU_EXECUTE_FLAGS_DEFINES_SVH
`define EIGHT_BIT_CPU_EXECUTE_FLAGS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPUEX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CPUEX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cpuex_pkg.sv
// ----------------------------------------------------------------------------
// Execute unit package
// Operation codes and the structures passed between the execute unit parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpuex_pkg;

  typedef enum logic [5:0] {
    CMD_ADC   = 6'd0,
    CMD_AND   = 6'd1,
    CMD_ORA   = 6'd2,
    CMD_EOR   = 6'd3,
    CMD_CMP   = 6'd4,
    CMD_CPX   = 6'd5,
    CMD_CPY   = 6'd6,
    CMD_ASL_A = 6'd7,
    CMD_LSR_A = 6'd8,
    CMD_ROL_A = 6'd9,
    CMD_ROR_A = 6'd10,
    CMD_ASL_M = 6'd11,
    CMD_LSR_M = 6'd12,
    CMD_ROL_M = 6'd13,
    CMD_ROR_M = 6'd14,
    CMD_INC   = 6'd15,
    CMD_DEC   = 6'd16,
    CMD_INX   = 6'd17,
    CMD_DEX   = 6'd18,
    CMD_INY   = 6'd19,
    CMD_DEY   = 6'd20,
    CMD_LDA   = 6'd21,
    CMD_LDX   = 6'd22,
    CMD_LDY   = 6'd23,
    CMD_BIT   = 6'd24,
    CMD_CLC   = 6'd25,
    CMD_CLD   = 6'd26,
    CMD_CLI   = 6'd27,
    CMD_CLV   = 6'd28,
    CMD_SEC   = 6'd29,
    CMD_SED   = 6'd30,
    CMD_SEI   = 6'd31,
    CMD_PHA   = 6'd32,
    CMD_PHP   = 6'd33,
    CMD_PLA   = 6'd34,
    CMD_PLP   = 6'd35,
    CMD_BCC   = 6'd36,
    CMD_BCS   = 6'd37,
    CMD_BEQ   = 6'd38,
    CMD_BNE   = 6'd39,
    CMD_BMI   = 6'd40,
    CMD_BPL   = 6'd41,
    CMD_BVC   = 6'd42,
    CMD_BVS   = 6'd43,
    CMD_NOP   = 6'd44
  } cmd_t;

  typedef struct packed {
    logic n;
    logic v;
    logic b;
    logic d;
    logic i;
    logic z;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    flags_t     flags;
  } arch_t;

  typedef struct packed {
    logic [5:0]  command;
    logic [7:0]  operand;
    logic [15:0] pc_in;
  } item_t;

  typedef struct packed {
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  status_out;
    logic [7:0]  write_data;
    logic        write_enable;
    logic        branch_taken;
    logic [15:0] next_pc;
  } result_t;

endpackage

>>> rtl/cpuex_if.sv
// ----------------------------------------------------------------------------
// Execute unit channels
// Valid/ready channels for instruction requests and execution results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cpuex_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  command;
  logic [7:0]  operand;
  logic [15:0] pc_in;

  modport source (output valid, output command, output operand, output pc_in, input ready);
  modport sink (input valid, input command, input operand, input pc_in, output ready);
endinterface

interface cpuex_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  acc_out;
  logic [7:0]  x_out;
  logic [7:0]  y_out;
  logic [7:0]  status_out;
  logic [7:0]  write_data;
  logic        write_enable;
  logic        branch_taken;
  logic [15:0] next_pc;

  modport source (
    output valid, output acc_out, output x_out, output y_out, output status_out,
    output write_data, output write_enable, output branch_taken, output next_pc,
    input ready
  );
  modport sink (
    input valid, input acc_out, input x_out, input y_out, input status_out,
    input write_data, input write_enable, input branch_taken, input next_pc,
    output ready
  );
endinterface

>>> rtl/eight_bit_cpu_execute_flags.sv
// The unit takes one request per clock while its result is not stalled and delivers one
// result per request. A request in the request register is executed against A, X, Y and
// the flags once the result register is free; the result register is then loaded and the
// registers are updated together, and the result is offered from the result register.
// Sustained throughput is one request per cycle while the result moves on, set by the
// combinational datapath between the request and result registers; a stalled result
// holds the request register, and new requests are taken whenever the result moves on.
// ----------------------------------------------------------------------------
// Execute unit top level
// Request register, architectural registers, datapath and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "eight_bit_cpu_execute_flags_defines.svh"

module eight_bit_cpu_execute_flags
  import cpuex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  cpuex_in_if.sink    in_chan,
  cpuex_out_if.source out_chan
);

  arch_t   state_r;
  arch_t   state_nxt;
  logic    s1_valid_r;
  logic    s1_valid_nxt;
  item_t   s1_item_r;
  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_res_r;
  result_t exec_res;
  logic    s2_free;
  logic    exec_fire;
  logic    in_fire;

  assign s2_free   = ~out_valid_r | out_chan.ready;
  assign exec_fire = s1_valid_r & s2_free;
  assign in_chan.ready = ~s1_valid_r | s2_free;
  assign in_fire   = in_chan.valid & in_chan.ready;

  assign s1_valid_nxt  = in_fire | (s1_valid_r & ~exec_fire);
  assign out_valid_nxt = exec_fire | (out_valid_r & ~out_chan.ready);

  cpuex_alu u_alu (
    .state_cur (state_r),
    .item      (s1_item_r),
    .state_nxt (state_nxt),
    .result    (exec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= '{command: in_chan.command, operand: in_chan.operand,
                     pc_in: in_chan.pc_in};
    end
    if (exec_fire) begin
      out_res_r <= exec_res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.acc_out      = out_res_r.acc_out;
  assign out_chan.x_out        = out_res_r.x_out;
  assign out_chan.y_out        = out_res_r.y_out;
  assign out_chan.status_out   = out_res_r.status_out;
  assign out_chan.write_data   = out_res_r.write_data;
  assign out_chan.write_enable = out_res_r.write_enable;
  assign out_chan.branch_taken = out_res_r.branch_taken;
  assign out_chan.next_pc      = out_res_r.next_pc;

  `CPUEX_ASSERT_NEXT(a_exec_loads_result, clk, rst_n, exec_fire, out_valid_r, "Executed request did not reach the result register.")
  `CPUEX_ASSERT_NEXT(a_state_holds, clk, rst_n, !exec_fire, $stable(state_r), "Registers changed without an executed request.")
  `CPUEX_ASSERT_NEXT(a_request_held, clk, rst_n, s1_valid_r && !s2_free, s1_valid_r && $stable(s1_item_r), "Stalled request was lost or altered.")
  `CPUEX_ASSERT_IMPL(a_wdata_clear, clk, rst_n, out_valid_r && !out_res_r.write_enable, out_res_r.write_data == 8'h00, "Write data not clear without a write.")

endmodule

>>> rtl/cpuex_alu.sv
// ----------------------------------------------------------------------------
// Execute unit datapath
// Computes the next register and flag state and the result of one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpuex_alu
  import cpuex_pkg::*;
(
  input  arch_t   state_cur,
  input  item_t   item,
  output arch_t   state_nxt,
  output result_t result
);

  typedef enum logic [1:0] {
    SH_ASL = 2'd0,
    SH_LSR = 2'd1,
    SH_ROL = 2'd2,
    SH_ROR = 2'd3
  } shift_t;

  // Returns the carry out in bit 8 and the shifted byte below it.
  function automatic logic [8:0] shift_byte(input shift_t kind, input logic [7:0] v,
                                            input logic cin);
    logic [8:0] r;
    unique case (kind)
      SH_ASL:  r = {v[7], v[6:0], 1'b0};
      SH_LSR:  r = {v[0], 1'b0, v[7:1]};
      SH_ROL:  r = {v[7], v[6:0], cin};
      SH_ROR:  r = {v[0], cin, v[7:1]};
      default: r = {1'b0, v};
    endcase
    return r;
  endfunction

  cmd_t        cmd;
  logic [7:0]  m;
  logic [8:0]  sum;
  logic [7:0]  cmp_reg;
  logic [7:0]  diff;
  logic [8:0]  sh;
  logic [7:0]  nz_val;
  logic        nz_upd;
  logic [7:0]  wdata;
  logic        we;
  logic        is_branch;
  logic        cond;
  flags_t      f;

  assign cmd = cmd_t'(item.command);
  assign m   = item.operand;
  assign f   = state_cur.flags;

  always_comb begin
    state_nxt = state_cur;
    sum       = {1'b0, state_cur.acc} + {1'b0, m} + {8'h00, f.c};
    cmp_reg   = state_cur.acc;
    diff      = 8'h00;
    sh        = 9'h000;
    nz_val    = 8'h00;
    nz_upd    = 1'b0;
    wdata     = 8'h00;
    we        = 1'b0;
    is_branch = 1'b0;
    cond      = 1'b0;

    unique case (cmd)
      CMD_ADC: begin
        state_nxt.acc     = sum[7:0];
        state_nxt.flags.c = sum[8];
        state_nxt.flags.v = (state_cur.acc[7] ^ sum[7]) & (m[7] ^ sum[7]);
        nz_val = sum[7:0];
        nz_upd = 1'b1;
      end
      CMD_AND: begin
        state_nxt.acc = state_cur.acc & m;
        nz_val = state_cur.acc & m;
        nz_upd = 1'b1;
      end
      CMD_ORA: begin
        state_nxt.acc = state_cur.acc | m;
        nz_val = state_cur.acc | m;
        nz_upd = 1'b1;
      end
      CMD_EOR: begin
        state_nxt.acc = state_cur.acc ^ m;
        nz_val = state_cur.acc ^ m;
        nz_upd = 1'b1;
      end
      CMD_CMP, CMD_CPX, CMD_CPY: begin
        if (cmd == CMD_CPX) begin
          cmp_reg = state_cur.x;
        end else if (cmd == CMD_CPY) begin
          cmp_reg = state_cur.y;
        end
        diff = cmp_reg - m;
        state_nxt.flags.c = (cmp_reg >= m);
        nz_val = diff;
        nz_upd = 1'b1;
      end
      CMD_ASL_A, CMD_LSR_A, CMD_ROL_A, CMD_ROR_A: begin
        unique case (cmd)
          CMD_ASL_A: sh = shift_byte(SH_ASL, state_cur.acc, f.c);
          CMD_LSR_A: sh = shift_byte(SH_LSR, state_cur.acc, f.c);
          CMD_ROL_A: sh = shift_byte(SH_ROL, state_cur.acc, f.c);
          default:   sh = shift_byte(SH_ROR, state_cur.acc, f.c);
        endcase
        state_nxt.acc     = sh[7:0];
        state_nxt.flags.c = sh[8];
        nz_val = sh[7:0];
        nz_upd = 1'b1;
      end
      CMD_ASL_M, CMD_LSR_M, CMD_ROL_M, CMD_ROR_M: begin
        unique case (cmd)
          CMD_ASL_M: sh = shift_byte(SH_ASL, m, f.c);
          CMD_LSR_M: sh = shift_byte(SH_LSR, m, f.c);
          CMD_ROL_M: sh = shift_byte(SH_ROL, m, f.c);
          default:   sh = shift_byte(SH_ROR, m, f.c);
        endcase
        state_nxt.flags.c = sh[8];
        wdata  = sh[7:0];
        we     = 1'b1;
        nz_val = sh[7:0];
        nz_upd = 1'b1;
      end
      CMD_INC: begin
        wdata  = m + 8'h01;
        we     = 1'b1;
        nz_val = m + 8'h01;
        nz_upd = 1'b1;
      end
      CMD_DEC: begin
        wdata  = m - 8'h01;
        we     = 1'b1;
        nz_val = m - 8'h01;
        nz_upd = 1'b1;
      end
      CMD_INX: begin
        state_nxt.x = state_cur.x + 8'h01;
        nz_val = state_cur.x + 8'h01;
        nz_upd = 1'b1;
      end
      CMD_DEX: begin
        state_nxt.x = state_cur.x - 8'h01;
        nz_val = state_cur.x - 8'h01;
        nz_upd = 1'b1;
      end
      CMD_INY: begin
        state_nxt.y = state_cur.y + 8'h01;
        nz_val = state_cur.y + 8'h01;
        nz_upd = 1'b1;
      end
      CMD_DEY: begin
        state_nxt.y = state_cur.y - 8'h01;
        nz_val = state_cur.y - 8'h01;
        nz_upd = 1'b1;
      end
      CMD_LDA, CMD_PLA: begin
        state_nxt.acc = m;
        nz_val = m;
        nz_upd = 1'b1;
      end
      CMD_LDX: begin
        state_nxt.x = m;
        nz_val = m;
        nz_upd = 1'b1;
      end
      CMD_LDY: begin
        state_nxt.y = m;
        nz_val = m;
        nz_upd = 1'b1;
      end
      CMD_BIT: begin
        state_nxt.flags.z = ((state_cur.acc & m) == 8'h00);
        state_nxt.flags.n = m[7];
        state_nxt.flags.v = m[6];
      end
      CMD_CLC: state_nxt.flags.c = 1'b0;
      CMD_CLD: state_nxt.flags.d = 1'b0;
      CMD_CLI: state_nxt.flags.i = 1'b0;
      CMD_CLV: state_nxt.flags.v = 1'b0;
      CMD_SEC: state_nxt.flags.c = 1'b1;
      CMD_SED: state_nxt.flags.d = 1'b1;
      CMD_SEI: state_nxt.flags.i = 1'b1;
      CMD_PHA: begin
        wdata = state_cur.acc;
        we    = 1'b1;
      end
      CMD_PHP: begin
        wdata = {f.n, f.v, 1'b1, 1'b1, f.d, f.i, f.z, f.c};
        we    = 1'b1;
      end
      CMD_PLP: state_nxt.flags = {m[7], m[6], m[4], m[3], m[2], m[1], m[0]};
      CMD_BCC: begin
        is_branch = 1'b1;
        cond      = ~f.c;
      end
      CMD_BCS: begin
        is_branch = 1'b1;
        cond      = f.c;
      end
      CMD_BEQ: begin
        is_branch = 1'b1;
        cond      = f.z;
      end
      CMD_BNE: begin
        is_branch = 1'b1;
        cond      = ~f.z;
      end
      CMD_BMI: begin
        is_branch = 1'b1;
        cond      = f.n;
      end
      CMD_BPL: begin
        is_branch = 1'b1;
        cond      = ~f.n;
      end
      CMD_BVC: begin
        is_branch = 1'b1;
        cond      = ~f.v;
      end
      CMD_BVS: begin
        is_branch = 1'b1;
        cond      = f.v;
      end
      CMD_NOP: ;
      default: ;
    endcase

    if (nz_upd) begin
      state_nxt.flags.n = nz_val[7];
      state_nxt.flags.z = (nz_val == 8'h00);
    end
  end

  always_comb begin
    result.acc_out      = state_nxt.acc;
    result.x_out        = state_nxt.x;
    result.y_out        = state_nxt.y;
    result.status_out   = {state_nxt.flags.n, state_nxt.flags.v, 1'b1, state_nxt.flags.b,
                           state_nxt.flags.d, state_nxt.flags.i, state_nxt.flags.z,
                           state_nxt.flags.c};
    result.write_data   = wdata;
    result.write_enable = we;
    result.branch_taken = is_branch & cond;
    result.next_pc      = (is_branch & cond) ? (item.pc_in + {{8{m[7]}}, m}) : item.pc_in;
  end

endmodule
